// ----- rtl/fba_pkg.sv -----
// shared types and constants of the frame bitmap allocator
// field widths, command and status codes, controller/datapath handshake structs
// no dependencies

package fba_pkg;

    // default sizing
    localparam int MAX_FRAMES_DEF = 32768;
    localparam int WORD_BITS_DEF  = 32;

    // longest run an allocate-run command may ask for
    localparam int MAX_RUN = 256;

    // item field widths
    localparam int CMD_W    = 3;
    localparam int FRAME_W  = 15;
    localparam int RUN_W    = 9;
    localparam int CFG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 16;

    // stream packing
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = STATUS_W;

    localparam logic [CFG_W-1:0] MANAGED_RESET = 16'd32768;

    // commands
    localparam logic [CMD_W-1:0] CMD_MARK      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TEST      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ALLOC_ONE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ALLOC_RUN = 3'd4;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd2;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_CAPTURE   = 4'd1,
        OP_DECODE    = 4'd2,
        OP_CLEAR     = 4'd3,
        OP_BIT_RD    = 4'd4,
        OP_BIT_WR    = 4'd5,
        OP_SCAN_INIT = 4'd6,
        OP_SCAN      = 4'd7,
        OP_FILL_RD   = 4'd8,
        OP_FILL_WR   = 4'd9
    } fba_op_t;

    typedef struct packed {
        fba_op_t op;
        logic    load_out;
    } fba_ctl_t;

    typedef struct packed {
        logic clear_last;
        logic bit_cmd;
        logic alloc_cmd;
        logic in_range;
        logic alloc_ok;
        logic found;
        logic scan_last;
        logic fill_last;
        logic out_free;
    } fba_sts_t;

endpackage

// ----- rtl/fba_ram.sv -----
// generic single-port ram with registered read data (read-first)
// no dependencies

module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/fba_ctrl.sv -----
// controller of the frame bitmap allocator: one-hot sequencer over clear, bit ops,
// scan and fill; depends on fba_pkg

module fba_ctrl
    import fba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  fba_sts_t sts,
    output fba_ctl_t ctl
);

    typedef enum logic [9:0] {
        ST_CLEAR     = 10'b0000000001,
        ST_IDLE      = 10'b0000000010,
        ST_DECODE    = 10'b0000000100,
        ST_BIT_RD    = 10'b0000001000,
        ST_BIT_WR    = 10'b0000010000,
        ST_SCAN_INIT = 10'b0000100000,
        ST_SCAN      = 10'b0001000000,
        ST_FILL_RD   = 10'b0010000000,
        ST_FILL_WR   = 10'b0100000000,
        ST_RESP      = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        ctl.op       = OP_NONE;
        ctl.load_out = 1'b0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.op = OP_CLEAR;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.op     = OP_CAPTURE;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                ctl.op = OP_DECODE;
                if (sts.bit_cmd && sts.in_range)
                begin
                    state_next = ST_BIT_RD;
                end
                else if (sts.alloc_cmd && sts.alloc_ok)
                begin
                    state_next = ST_SCAN_INIT;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_BIT_RD:
            begin
                ctl.op     = OP_BIT_RD;
                state_next = ST_BIT_WR;
            end
            ST_BIT_WR:
            begin
                ctl.op     = OP_BIT_WR;
                state_next = ST_RESP;
            end
            ST_SCAN_INIT:
            begin
                ctl.op     = OP_SCAN_INIT;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                ctl.op = OP_SCAN;
                if (sts.found)
                begin
                    state_next = ST_FILL_RD;
                end
                else if (sts.scan_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_FILL_RD:
            begin
                ctl.op     = OP_FILL_RD;
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                ctl.op = OP_FILL_WR;
                if (sts.fill_last)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_FILL_RD;
                end
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/fba_dp.sv -----
// datapath of the frame bitmap allocator: bitmap ram, used count, word scanner,
// run filler and result register; depends on fba_pkg and fba_ram

module fba_dp
    import fba_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fba_ctl_t            ctl,
    output fba_sts_t            sts,
    input  logic                cfg_valid,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic [CMD_W-1:0]    in_cmd,
    input  logic [FRAME_W-1:0]  in_frame,
    input  logic [RUN_W-1:0]    in_run,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [FRAME_W-1:0]  out_frame,
    output logic                out_was,
    output logic [USED_W-1:0]   out_used
);

    localparam int NWORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BW     = $clog2(WORD_BITS);
    localparam int FW     = $clog2(MAX_FRAMES + 1);
    localparam int XW0    = (AW + BW > FW) ? AW + BW : FW;
    localparam int XW     = ((XW0 > CFG_W) ? XW0 : CFG_W) + 1;
    localparam int LW     = BW + 1;
    localparam int SW     = ((RUN_W > LW) ? RUN_W : LW) + 1;
    // frame / WORD_BITS by reciprocal, exact for every frame_index value
    localparam int DIV_S  = FRAME_W + BW;
    localparam int RECIP  = (2 ** DIV_S) / WORD_BITS + 1;
    localparam int RCP_W  = $clog2(RECIP + 1);
    localparam int PW     = FRAME_W + RCP_W;

    // registers
    logic [CFG_W-1:0]    managed_reg, managed_next;
    logic [FW-1:0]       count_reg, count_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [FRAME_W-1:0]  fi_reg, fi_next;
    logic [RUN_W-1:0]    want_reg, want_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [BW-1:0]       bo_reg, bo_next;
    logic [XW-1:0]       base_reg, base_next;
    logic [RUN_W-1:0]    carry_reg, carry_next;
    logic [XW-1:0]       start_reg, start_next;
    logic [BW-1:0]       endbit_reg, endbit_next;
    logic                first_reg, first_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [FRAME_W-1:0]  res_frame_reg, res_frame_next;
    logic                res_was_reg, res_was_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [FRAME_W-1:0]  out_frame_reg, out_frame_next;
    logic                out_was_reg, out_was_next;
    logic [USED_W-1:0]   out_used_reg, out_used_next;

    // ram port
    logic                 ram_en;
    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    // decode
    logic [XW-1:0]       lim;
    logic                is_bit;
    logic                is_alloc;
    logic                in_range;
    logic                alloc_ok;
    logic [STATUS_W-1:0] pre_status;
    logic [PW-1:0]       div_prod;
    logic [XW-1:0]       div_q;
    logic [XW-1:0]       div_r;
    logic [XW-1:0]       count_ext;

    // word scanner
    logic [XW-1:0]        left;
    logic [WORD_BITS-1:0] used_w;
    logic [LW-1:0]        last_pos [BW+1][WORD_BITS];
    logic [SW-1:0]        streak [WORD_BITS];
    logic [WORD_BITS-1:0] hit;
    logic                 scan_found;
    logic [BW-1:0]        scan_j;
    logic [RUN_W-1:0]     carry_new;
    logic [XW-1:0]        scan_start;
    logic                 scan_last;

    // run filler and single-bit ops
    logic [BW-1:0]        fill_lo;
    logic [BW-1:0]        fill_hi;
    logic [WORD_BITS-1:0] fill_mask;
    logic                 fill_last;
    logic [WORD_BITS-1:0] bit_mask;
    logic                 bit_old;

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_bitmap (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ---------------- decode ----------------
    assign lim = (XW'(managed_reg) > XW'(MAX_FRAMES)) ? XW'(MAX_FRAMES) : XW'(managed_reg);

    assign is_bit   = cmd_reg inside {CMD_MARK, CMD_FREE, CMD_TEST};
    assign is_alloc = cmd_reg inside {CMD_ALLOC_ONE, CMD_ALLOC_RUN};
    assign in_range = XW'(fi_reg) < lim;
    assign alloc_ok = (want_reg != '0) && (int'(want_reg) <= MAX_RUN) && (lim != '0);

    always_comb
    begin
        if (is_bit && !in_range)
        begin
            pre_status = ST_RANGE;
        end
        else if (is_alloc && !alloc_ok)
        begin
            pre_status = ST_NOSPACE;
        end
        else
        begin
            pre_status = ST_OK;
        end
    end

    assign div_prod  = PW'(fi_reg) * PW'(RECIP);
    assign div_q     = XW'(div_prod >> DIV_S);
    assign div_r     = XW'(fi_reg) - div_q * XW'(WORD_BITS);
    assign count_ext = XW'(count_reg);

    // ---------------- word scanner ----------------
    // frames at or above the limit count as used so no run can reach them
    assign left = lim - base_reg;

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            used_w[j] = ram_rdata[j] | !(XW'(j) < left);
        end
    end

    // prefix search for the highest used bit at or below each position (0 = none)
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            last_pos[0][j] = used_w[j] ? LW'(j + 1) : '0;
        end
        for (int k = 0; k < BW; k++)
        begin
            for (int j = 0; j < WORD_BITS; j++)
            begin
                if ((j >= (1 << k)) && (last_pos[k][j] == '0))
                begin
                    last_pos[k + 1][j] = last_pos[k][j - (1 << k)];
                end
                else
                begin
                    last_pos[k + 1][j] = last_pos[k][j];
                end
            end
        end
    end

    // free streak ending at each position, carried across words
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (last_pos[BW][j] == '0)
            begin
                streak[j] = SW'(carry_reg) + SW'(j + 1);
            end
            else
            begin
                streak[j] = SW'(j + 1) - SW'(last_pos[BW][j]);
            end
            hit[j] = streak[j] >= SW'(want_reg);
        end
    end

    always_comb
    begin
        scan_j = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (hit[j])
            begin
                scan_j = BW'(j);
            end
        end
    end

    assign scan_found = |hit;
    assign carry_new  = (streak[WORD_BITS-1] > SW'({RUN_W{1'b1}})) ? {RUN_W{1'b1}}
                                                                   : RUN_W'(streak[WORD_BITS-1]);
    assign scan_start = base_reg + XW'(scan_j) + XW'(1) - XW'(want_reg);
    assign scan_last  = (base_reg + XW'(WORD_BITS)) >= lim;

    // ---------------- run filler ----------------
    // fill runs backward from the word where the run ends
    assign fill_last = start_reg >= base_reg;
    assign fill_lo   = (start_reg > base_reg) ? BW'(start_reg - base_reg) : '0;
    assign fill_hi   = first_reg ? endbit_reg : BW'(WORD_BITS - 1);

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            fill_mask[j] = (BW'(j) >= fill_lo) && (BW'(j) <= fill_hi);
            bit_mask[j]  = BW'(j) == bo_reg;
        end
    end

    assign bit_old = |(ram_rdata & bit_mask);

    // ---------------- next state ----------------
    always_comb
    begin
        managed_next    = managed_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        fi_next         = fi_reg;
        want_next       = want_reg;
        addr_next       = addr_reg;
        bo_next         = bo_reg;
        base_next       = base_reg;
        carry_next      = carry_reg;
        start_next      = start_reg;
        endbit_next     = endbit_reg;
        first_next      = first_reg;
        res_status_next = res_status_reg;
        res_frame_next  = res_frame_reg;
        res_was_next    = res_was_reg;
        ram_en          = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = addr_reg;
        ram_wdata       = ram_rdata;

        if (cfg_valid)
        begin
            managed_next = cfg_data;
        end

        case (ctl.op)
            OP_CAPTURE:
            begin
                cmd_next  = in_cmd;
                fi_next   = in_frame;
                want_next = (in_cmd == CMD_ALLOC_ONE) ? RUN_W'(1) : in_run;
            end
            OP_DECODE:
            begin
                addr_next       = div_q[AW-1:0];
                bo_next         = div_r[BW-1:0];
                res_status_next = pre_status;
                res_frame_next  = fi_reg;
                res_was_next    = 1'b0;
            end
            OP_CLEAR:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = '0;
                addr_next = addr_reg + AW'(1);
            end
            OP_BIT_RD:
            begin
                ram_en = 1'b1;
            end
            OP_BIT_WR:
            begin
                res_was_next = bit_old;
                if ((cmd_reg == CMD_MARK) && !bit_old)
                begin
                    ram_en     = 1'b1;
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata | bit_mask;
                    count_next = count_reg + FW'(1);
                end
                else if ((cmd_reg == CMD_FREE) && bit_old)
                begin
                    ram_en     = 1'b1;
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata & ~bit_mask;
                    count_next = count_reg - FW'(1);
                end
            end
            OP_SCAN_INIT:
            begin
                ram_en     = 1'b1;
                ram_addr   = '0;
                addr_next  = '0;
                base_next  = '0;
                carry_next = '0;
            end
            OP_SCAN:
            begin
                if (scan_found)
                begin
                    start_next  = scan_start;
                    endbit_next = scan_j;
                    first_next  = 1'b1;
                end
                else if (scan_last)
                begin
                    res_status_next = ST_NOSPACE;
                end
                else
                begin
                    ram_en     = 1'b1;
                    ram_addr   = addr_reg + AW'(1);
                    addr_next  = addr_reg + AW'(1);
                    base_next  = base_reg + XW'(WORD_BITS);
                    carry_next = carry_new;
                end
            end
            OP_FILL_RD:
            begin
                ram_en = 1'b1;
            end
            OP_FILL_WR:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | fill_mask;
                if (fill_last)
                begin
                    count_next     = count_reg + FW'(want_reg);
                    res_frame_next = start_reg[FRAME_W-1:0];
                end
                else
                begin
                    addr_next  = addr_reg - AW'(1);
                    base_next  = base_reg - XW'(WORD_BITS);
                    first_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // result register, free again once the item is taken
    always_comb
    begin
        out_status_next = out_status_reg;
        out_frame_next  = out_frame_reg;
        out_was_next    = out_was_reg;
        out_used_next   = out_used_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if (ctl.load_out)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_frame_next  = res_frame_reg;
            out_was_next    = res_was_reg;
            out_used_next   = count_ext[USED_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            managed_reg   <= MANAGED_RESET;
            count_reg     <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            managed_reg   <= managed_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        fi_reg         <= fi_next;
        want_reg       <= want_next;
        bo_reg         <= bo_next;
        base_reg       <= base_next;
        carry_reg      <= carry_next;
        start_reg      <= start_next;
        endbit_reg     <= endbit_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_frame_reg  <= res_frame_next;
        res_was_reg    <= res_was_next;
        out_status_reg <= out_status_next;
        out_frame_reg  <= out_frame_next;
        out_was_reg    <= out_was_next;
        out_used_reg   <= out_used_next;
    end

    assign sts.clear_last = addr_reg == AW'(NWORDS - 1);
    assign sts.bit_cmd    = is_bit;
    assign sts.alloc_cmd  = is_alloc;
    assign sts.in_range   = in_range;
    assign sts.alloc_ok   = alloc_ok;
    assign sts.found      = scan_found;
    assign sts.scan_last  = scan_last;
    assign sts.fill_last  = fill_last;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_frame  = out_frame_reg;
    assign out_was    = out_was_reg;
    assign out_used   = out_used_reg;

endmodule

// ----- rtl/frame_bitmap_allocator.sv -----
// top level of the frame bitmap allocator: stream ports, config register port
// depends on fba_pkg, fba_ctrl, fba_dp (which holds fba_ram)

// Page frame allocator over a used/free bitmap held in one single-port RAM of
// WORD_BITS-bit words (1 = used), with a count of used frames. Each command item
// yields exactly one result item. After reset the block sweeps the RAM to zero,
// one word per cycle, and takes no item until done; the managed_frames register
// can be written meanwhile. In-range mark, free and test go through decode, RAM
// read, write back and result load; an out-of-range frame, an unknown command or
// a refused allocation goes through decode and result load only. Allocate one and
// allocate run go through decode, scan start, a scan of the bitmap words (up to
// ceil(managed_frames/WORD_BITS), 1024 at most by default), a read and a write
// back for each word touched by the run, and result load; the scan rate is set by
// the single RAM read port and the one-word-per-cycle run detector.
// One item is worked on at a time; a finished result waits in an output register,
// so the next item is accepted while the previous result has not yet been taken.

module frame_bitmap_allocator
    import fba_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // managed_frames register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    // command items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // frame_index [14:0], run_length [23:15]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,   // cmd [2:0]
    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // result_frame [14:0], was_used [15],
                                                 // used_frames [31:16]
    output logic [M_TUSER_W-1:0] m_axis_tuser    // status [1:0]
);

    fba_ctl_t            ctl;
    fba_sts_t            sts;
    logic [FRAME_W-1:0]  res_frame;
    logic                res_was;
    logic [USED_W-1:0]   res_used;
    logic [STATUS_W-1:0] res_status;

    // the register is a plain flop, always writable
    assign cfg_ready = 1'b1;

    fba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    fba_dp #(
        .MAX_FRAMES (MAX_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_cmd     (s_axis_tuser),
        .in_frame   (s_axis_tdata[FRAME_W-1:0]),
        .in_run     (s_axis_tdata[FRAME_W +: RUN_W]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (res_status),
        .out_frame  (res_frame),
        .out_was    (res_was),
        .out_used   (res_used)
    );

    // pack result fields, lowest first
    assign m_axis_tdata = {res_used, res_was, res_frame};
    assign m_axis_tuser = res_status;

endmodule

// ----- tb/sv/frame_bitmap_allocator_tb.sv -----
// self-checking testbench for frame_bitmap_allocator: directed and random command items,
// a bit-exact allocator model predicting each result, random idling and long back-pressure
// depends on fba_pkg and the frame_bitmap_allocator rtl

module frame_bitmap_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fba_pkg::*;

    localparam int WORD_COUNT = MAX_FRAMES_DEF / WORD_BITS_DEF;

    // no-handshake cycles before giving up; long legal gaps are the clearing pass,
    // a full 1024-word scan and the receiver hold of test_backpressure
    localparam int unsigned QUIET_LIMIT = 8000;

    // command codes past the last defined one
    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_ALLOC_RUN + 1'b1;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = '1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame;
        logic                was_used;
        logic [USED_W-1:0]   used;
    } frame_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // frame_index [14:0], run_length [23:15]
    logic [S_TUSER_W-1:0] s_axis_tuser;   // cmd [2:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // result_frame [14:0], was_used [15],
                                          // used_frames [31:16]
    logic [M_TUSER_W-1:0] m_axis_tuser;   // status [1:0]

    // allocator model state
    logic [WORD_BITS_DEF-1:0] usage_words [WORD_COUNT];
    int unsigned              used_total;
    logic [CFG_W-1:0]         managed_reg;

    frame_result_t expected_q[$];

    // run control shared between processes
    logic        idle_on;
    int unsigned rx_hold_len;

    // bookkeeping
    int unsigned errors;
    int unsigned commands_sent;
    int unsigned settings_used;
    int unsigned ok_seen;
    int unsigned range_seen;
    int unsigned nospace_seen;

    frame_bitmap_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // register values above the bitmap size act as the full bitmap
    function automatic int unsigned frame_limit();
        return (managed_reg > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : managed_reg;
    endfunction

    // update the allocator model with one command and return its result
    function automatic frame_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [FRAME_W-1:0] frame,
                                                    input logic [RUN_W-1:0] len);
        frame_result_t r;
        int unsigned   lim;
        int unsigned   want;
        int unsigned   run;
        int unsigned   start;
        logic          found;
        lim        = frame_limit();
        r.status   = ST_OK;
        r.frame    = frame;
        r.was_used = 1'b0;
        run        = 0;
        start      = 0;
        found      = 1'b0;
        if (cmd == CMD_MARK || cmd == CMD_FREE || cmd == CMD_TEST)
        begin
            if (frame >= lim)
                r.status = ST_RANGE;
            else
            begin
                r.was_used = usage_words[frame / WORD_BITS_DEF][frame % WORD_BITS_DEF];
                if (cmd == CMD_MARK && !r.was_used)
                begin
                    usage_words[frame / WORD_BITS_DEF][frame % WORD_BITS_DEF] = 1'b1;
                    used_total++;
                end
                if (cmd == CMD_FREE && r.was_used)
                begin
                    usage_words[frame / WORD_BITS_DEF][frame % WORD_BITS_DEF] = 1'b0;
                    used_total--;
                end
            end
        end
        else if (cmd == CMD_ALLOC_ONE || cmd == CMD_ALLOC_RUN)
        begin
            want = (cmd == CMD_ALLOC_ONE) ? 1 : len;
            // lowest-first scan; a run may not pass the managed limit
            if (want >= 1 && want <= MAX_RUN)
            begin
                for (int unsigned f = 0; f < lim && !found; f++)
                begin
                    if (usage_words[f / WORD_BITS_DEF][f % WORD_BITS_DEF])
                        run = 0;
                    else
                    begin
                        run++;
                        if (run == want)
                        begin
                            start = f + 1 - want;
                            found = 1'b1;
                        end
                    end
                end
            end
            if (found)
            begin
                for (int unsigned f = start; f < start + want; f++)
                    usage_words[f / WORD_BITS_DEF][f % WORD_BITS_DEF] = 1'b1;
                used_total += want;
                r.frame = start[FRAME_W-1:0];
            end
            else
                r.status = ST_NOSPACE;
        end
        r.used = used_total[USED_W-1:0];
        return r;
    endfunction

    // one command item; valid stays high afterwards unless a gap is drawn
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [FRAME_W-1:0] frame,
                                input logic [RUN_W-1:0] len);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {len, frame};
        do @(posedge clk); while (!s_axis_tready);
        expected_q.push_back(apply_command(cmd, frame, len));
        commands_sent++;
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    // register write; only called with no result outstanding
    task automatic write_managed(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        managed_reg = value;
        settings_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_commands(input int unsigned count, input int unsigned run_cap);
        logic [CMD_W-1:0]   cmd;
        logic [FRAME_W-1:0] frame;
        logic [RUN_W-1:0]   len;
        int unsigned        lim;
        int unsigned        pick;
        for (int unsigned i = 0; i < count; i++)
        begin
            lim  = frame_limit();
            pick = $urandom_range(0, 99);
            if (pick < 15)
                cmd = CMD_MARK;
            else if (pick < 45)
                cmd = CMD_FREE;
            else if (pick < 57)
                cmd = CMD_TEST;
            else if (pick < 75)
                cmd = CMD_ALLOC_ONE;
            else if (pick < 95)
                cmd = CMD_ALLOC_RUN;
            else
                cmd = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
            // frames mostly inside the managed range, some just past it
            pick = $urandom_range(0, 99);
            if (lim > 1024 && pick < 50)
                frame = FRAME_W'($urandom_range(0, 511));
            else if (lim == 0 || lim >= MAX_FRAMES_DEF || pick >= 95)
                frame = FRAME_W'($urandom_range(0, MAX_FRAMES_DEF - 1));
            else if (pick >= 85)
                frame = FRAME_W'($urandom_range(lim, (lim + 40 < MAX_FRAMES_DEF)
                                                      ? lim + 40 : MAX_FRAMES_DEF - 1));
            else
                frame = FRAME_W'($urandom_range(0, lim - 1));
            // short runs mostly, a few long and a few illegal lengths
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = RUN_W'($urandom_range(1, (run_cap < 8) ? run_cap : 8));
            else if (pick < 90)
                len = RUN_W'($urandom_range(1, run_cap));
            else
                len = RUN_W'($urandom_range(0, (1 << RUN_W) - 1));
            send_command(cmd, frame, len);
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_single_frame_commands();
        write_managed('1);
        send_command(CMD_TEST, '0, 9'd1);
        send_command(CMD_MARK, '0, 9'd1);
        send_command(CMD_MARK, '0, 9'd1);     // already used: no change
        send_command(CMD_TEST, '0, 9'd1);
        send_command(CMD_FREE, '0, 9'd1);
        send_command(CMD_FREE, '0, 9'd1);     // already free: no change
        send_command(CMD_MARK, '1, '1);
        send_command(CMD_TEST, '1, '0);
        send_command(CMD_FREE, '1, '1);
    endtask

    task automatic test_unknown_commands();
        send_command(CMD_UNUSED_FIRST, '1, '1);
        send_command(CMD_UNUSED_FIRST + 1'b1, '0, '0);
        send_command(CMD_UNUSED_LAST, '1, '1);
    endtask

    task automatic test_allocations();
        send_command(CMD_ALLOC_ONE, '0, '0);
        send_command(CMD_ALLOC_RUN, '0, RUN_W'(MAX_RUN));
        send_command(CMD_ALLOC_RUN, '0, '0);                  // zero length refused
        send_command(CMD_ALLOC_RUN, '0, RUN_W'(MAX_RUN + 1)); // too long
        send_command(CMD_ALLOC_RUN, '0, '1);
        send_command(CMD_ALLOC_RUN, '0, 9'd1);
    endtask

    // lowered limit: frames past it are out of range, used bits there stay counted
    task automatic test_shrunk_range();
        drain_results();
        write_managed(16'd40);
        send_command(CMD_TEST, 15'd39, 9'd1);
        send_command(CMD_TEST, 15'd40, 9'd1);
        send_command(CMD_MARK, 15'd40, 9'd1);
        send_command(CMD_FREE, 15'd40, 9'd1);
        send_command(CMD_ALLOC_ONE, '0, 9'd1);        // all 40 already used
        send_command(CMD_ALLOC_RUN, '0, 9'd1);
    endtask

    task automatic test_random_full_range();
        drain_results();
        write_managed('1);
        send_random_commands(100, MAX_RUN);
    endtask

    // limit ends inside the second word
    task automatic test_random_partial_word();
        drain_results();
        write_managed(16'd40);
        send_random_commands(100, 48);
    endtask

    task automatic test_random_tiny_range();
        drain_results();
        write_managed('0);
        send_random_commands(30, 4);
        drain_results();
        write_managed(16'd1);
        send_random_commands(30, 4);
    endtask

    task automatic test_random_word_aligned();
        drain_results();
        write_managed(16'd96);
        send_random_commands(90, 64);
    endtask

    task automatic test_random_long_runs();
        drain_results();
        write_managed(16'd300);
        send_random_commands(100, MAX_RUN);
    endtask

    // receiver stops for a long stretch while commands keep coming
    task automatic test_backpressure();
        logic saved_idle;
        saved_idle = idle_on;
        idle_on    = 1'b0;
        rx_hold_len = 300;
        send_random_commands(24, 16);
        idle_on = saved_idle;
        drain_results();
    endtask

    // sender waits for every result in the middle of a stream
    task automatic test_sender_pause();
        write_managed(16'd64);
        send_random_commands(10, 16);
        drain_results();
        send_random_commands(10, 16);
    endtask

    task automatic test_random_no_idle();
        drain_results();
        idle_on = 1'b0;
        write_managed(MANAGED_RESET);
        send_random_commands(60, MAX_RUN);
    endtask

    // ------------------------------------------------------------ processes

    // receiver: random stall bursts plus one long hold when asked
    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (rx_hold_len != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left  = rx_hold_len - 1;
                rx_hold_len = 0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // compare each result item with the oldest prediction
    always @(posedge clk)
    begin : check_results
        frame_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d tdata %h", $time,
                         m_axis_tuser, m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (m_axis_tuser !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[14:0] !== exp_r.frame)
                begin
                    $display("%0t: result_frame expected %0d actual %0d", $time,
                             exp_r.frame, m_axis_tdata[14:0]);
                    errors++;
                end
                if (m_axis_tdata[15] !== exp_r.was_used)
                begin
                    $display("%0t: was_used expected %0d actual %0d", $time,
                             exp_r.was_used, m_axis_tdata[15]);
                    errors++;
                end
                if (m_axis_tdata[31:16] !== exp_r.used)
                begin
                    $display("%0t: used_frames expected %0d actual %0d", $time,
                             exp_r.used, m_axis_tdata[31:16]);
                    errors++;
                end
                case (exp_r.status)
                    ST_OK:      ok_seen++;
                    ST_RANGE:   range_seen++;
                    ST_NOSPACE: nospace_seen++;
                    default:    ;
                endcase
            end
        end
    end

    // watchdog: too long without any handshake on any channel
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("** frame_bitmap_allocator: FAILED **");
        $finish;
    end

    initial
    begin : main
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        idle_on       = 1'b1;
        rx_hold_len   = 0;
        errors        = 0;
        commands_sent = 0;
        settings_used = 0;
        ok_seen       = 0;
        range_seen    = 0;
        nospace_seen  = 0;
        for (int i = 0; i < WORD_COUNT; i++)
            usage_words[i] = '0;
        used_total  = 0;
        managed_reg = MANAGED_RESET;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // the block clears its bitmap first; the command handshakes wait it out
        test_single_frame_commands();
        test_unknown_commands();
        test_allocations();
        test_shrunk_range();
        test_random_full_range();
        test_random_partial_word();
        test_random_tiny_range();
        test_random_word_aligned();
        test_random_long_runs();
        test_backpressure();
        test_sender_pause();
        test_random_no_idle();

        drain_results();
        repeat (64) @(posedge clk);

        $display("covered %0d commands over %0d register writes", commands_sent, settings_used);
        $display("results: %0d ok, %0d out of range, %0d no space, %0d failures",
                 ok_seen, range_seen, nospace_seen, errors);
        if (errors == 0)
            $display("** frame_bitmap_allocator: PASSED **");
        else
            $display("** frame_bitmap_allocator: FAILED **");
        $finish;
    end

endmodule

// ----- frame_bitmap_allocator.f -----
rtl/fba_pkg.sv
rtl/fba_ram.sv
rtl/fba_ctrl.sv
rtl/fba_dp.sv
rtl/frame_bitmap_allocator.sv
tb/sv/frame_bitmap_allocator_tb.sv
